// ===== sv/playfair_pair_cipher_macros.svh =====
// Assertion macros shared by the cipher RTL.
// No dependencies; assumes signals named clk and arst_n in the including module.
`ifndef PLAYFAIR_PAIR_CIPHER_MACROS_SVH
`define PLAYFAIR_PAIR_CIPHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfc assertion failed");
`define PFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfc assertion failed");
`else
`define PFC_ASSERT_NOW(label, ante, cons)
`define PFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/pfc_pkg.sv =====
// Types, constants and small helper functions for the pair cipher.
// No dependencies.
package pfc_pkg;

	localparam int SQ_CELLS = 25;
	localparam int LETTERS  = 26;

	typedef logic [4:0] cell_t;
	typedef logic [4:0] letter_t;
	typedef logic [2:0] coord_t;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_KEY    = 3'd1;
	localparam logic [2:0] CMD_FINISH = 3'd2;
	localparam logic [2:0] CMD_TEXT   = 3'd3;
	localparam logic [2:0] CMD_END    = 3'd4;

	localparam letter_t LETTER_I = 5'd8;
	localparam letter_t LETTER_J = 5'd9;
	localparam letter_t LAST_LETTER = 5'd25;
	localparam cell_t   FULL_COUNT = 5'd25;

	localparam logic [7:0] ASCII_UC_A = 8'd65;
	localparam logic [7:0] ASCII_UC_Z = 8'd90;
	localparam logic [7:0] ASCII_LC_A = 8'd97;
	localparam logic [7:0] ASCII_LC_Z = 8'd122;
	localparam logic [7:0] ASCII_PLUS = 8'd43;
	localparam logic [7:0] ASCII_DASH = 8'd45;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] char_code;
	} pfc_req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} pfc_rsp_t;

	// Cell indices and character overrides for one pair or odd tail.
	typedef struct packed {
		cell_t idx0;
		cell_t idx1;
		logic  plus0;
		logic  plus1;
		logic  pad1;
	} pfc_pair_t;

	// Returns {is_letter, letter index 0..25}.
	function automatic logic [5:0] decode_letter(input logic [7:0] code);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (code >= ASCII_UC_A && code <= ASCII_UC_Z) begin
				d = code - ASCII_UC_A;
				return {1'b1, d[4:0]};
			end
			if (code >= ASCII_LC_A && code <= ASCII_LC_Z) begin
				d = code - ASCII_LC_A;
				return {1'b1, d[4:0]};
			end
			return 6'd0;
		end
	endfunction

	// J shares every piece of bookkeeping with I.
	function automatic letter_t fold_j(input letter_t l);
		return (l == LETTER_J) ? LETTER_I : l;
	endfunction

	function automatic coord_t cell_row(input cell_t idx);
		if (idx >= 5'd20) return 3'd4;
		if (idx >= 5'd15) return 3'd3;
		if (idx >= 5'd10) return 3'd2;
		if (idx >= 5'd5)  return 3'd1;
		return 3'd0;
	endfunction

	function automatic coord_t cell_col(input cell_t idx);
		cell_t base;
		cell_t diff;
		begin
			base = ({2'b00, cell_row(idx)} << 2) + {2'b00, cell_row(idx)};
			diff = idx - base;
			return diff[2:0];
		end
	endfunction

	function automatic coord_t inc5(input coord_t x);
		return (x == 3'd4) ? 3'd0 : x + 3'd1;
	endfunction

	function automatic cell_t make_cell(input coord_t r, input coord_t c);
		return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
	endfunction

endpackage

// ===== sv/playfair_pair_cipher.sv =====
// Top level of the pair cipher: sequencer, key bookkeeping, output register.
// Depends on pfc_pkg, pfc_ram, pfc_pair_unit and playfair_pair_cipher_macros.svh.
//
//  channel | signals                     | moves
//  req     | req_valid, req_ready, req   | one command item (cmd, char_code)
//  rsp     | rsp_valid, rsp_ready, rsp   | one cipher character (out_char, last)
//
// Clear, key char and ignored items complete on acceptance. A key finish walks the 26 letters
// one per cycle through the single write port of each RAM.
// A text pair or odd tail takes two place reads and two square reads, each through the
// one registered read port of its RAM, plus any output stalls.
// Reset clears the seen bits, the fill count and the held letter; the RAMs need no clearing.
// A stalled output holds the sequencer in its emit states; req_ready is low meanwhile.
`include "playfair_pair_cipher_macros.svh"
module playfair_pair_cipher import pfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  pfc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output pfc_rsp_t rsp
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WALK = 4'd1;
	localparam logic [3:0] S_RDA  = 4'd2;
	localparam logic [3:0] S_RDB  = 4'd3;
	localparam logic [3:0] S_CALC = 4'd4;
	localparam logic [3:0] S_SQ0  = 4'd5;
	localparam logic [3:0] S_SQ1  = 4'd6;
	localparam logic [3:0] S_SQ2  = 4'd7;
	localparam logic [3:0] S_EM0  = 4'd8;
	localparam logic [3:0] S_EM1  = 4'd9;

	logic [3:0]         state_q;
	logic [LETTERS-1:0] seen_q;
	cell_t              fill_q;
	letter_t            held_q;
	logic               held_valid_q;
	letter_t            walk_q;
	letter_t            b_q;
	logic               tail_q;
	cell_t              pa_q;
	pfc_pair_t          pair_q;
	logic [7:0]         c0_q, c1_q;
	logic               rsp_valid_q;
	pfc_rsp_t           rsp_q;

	logic       accept;
	logic [5:0] dec;
	logic       is_letter;
	letter_t    in_letter;
	logic       full;
	logic       add_en;
	letter_t    add_letter;
	letter_t    add_fold;
	logic       add_do;
	letter_t    place_raddr;
	cell_t      place_rdata;
	cell_t      sq_raddr;
	letter_t    sq_rdata;
	pfc_pair_t  pair;
	logic       out_free;
	logic       emit;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign dec       = decode_letter(req.char_code);
	assign is_letter = dec[5];
	assign in_letter = dec[4:0];
	assign full      = (fill_q == FULL_COUNT);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign emit      = (state_q == S_EM0 || state_q == S_EM1) && out_free;

	// One key letter is placed per cycle, from a key char or from the finish walk.
	always_comb begin
		add_en     = 1'b0;
		add_letter = walk_q;
		if (state_q == S_WALK) begin
			add_en = 1'b1;
		end else if (accept && req.cmd == CMD_KEY && is_letter) begin
			add_en     = 1'b1;
			add_letter = in_letter;
		end
	end
	assign add_fold = fold_j(add_letter);
	assign add_do   = add_en && !full && !seen_q[add_fold];

	assign place_raddr = (state_q == S_RDA) ? fold_j(held_q) : fold_j(b_q);
	assign sq_raddr    = (state_q == S_SQ1) ? pair_q.idx1 : pair_q.idx0;

	pfc_ram #(.WIDTH(5), .DEPTH(SQ_CELLS)) u_square (
		.clk   (clk),
		.we    (add_do),
		.waddr (fill_q),
		.wdata (add_fold),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	pfc_ram #(.WIDTH(5), .DEPTH(LETTERS)) u_place (
		.clk   (clk),
		.we    (add_do),
		.waddr (add_fold),
		.wdata (fill_q),
		.raddr (place_raddr),
		.rdata (place_rdata)
	);

	pfc_pair_unit u_pair (
		.place_a (pa_q),
		.place_b (place_rdata),
		.a_is_j  (held_q == LETTER_J),
		.b_is_j  (b_q == LETTER_J),
		.tail    (tail_q),
		.pair    (pair)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seen_q       <= '0;
			fill_q       <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			walk_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (add_do) begin
				seen_q[add_fold] <= 1'b1;
				fill_q           <= fill_q + 5'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.cmd)
							CMD_CLEAR: begin
								seen_q       <= '0;
								fill_q       <= '0;
								held_q       <= '0;
								held_valid_q <= 1'b0;
							end
							CMD_FINISH: begin
								walk_q  <= '0;
								state_q <= S_WALK;
							end
							CMD_TEXT: begin
								if (full && is_letter) begin
									if (!held_valid_q) begin
										held_q       <= in_letter;
										held_valid_q <= 1'b1;
									end else begin
										state_q <= S_RDA;
									end
								end
							end
							CMD_END: begin
								if (full && held_valid_q) begin
									state_q <= S_RDA;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					walk_q <= walk_q + 5'd1;
					if (walk_q == LAST_LETTER) begin
						state_q <= S_IDLE;
					end
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_CALC;
				S_CALC: state_q <= S_SQ0;
				S_SQ0:  state_q <= S_SQ1;
				S_SQ1:  state_q <= S_SQ2;
				S_SQ2:  state_q <= S_EM0;
				S_EM0: begin
					if (out_free) begin
						state_q <= S_EM1;
					end
				end
				S_EM1: begin
					if (out_free) begin
						held_q       <= '0;
						held_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			b_q    <= in_letter;
			tail_q <= (req.cmd == CMD_END);
		end
		if (state_q == S_RDB) begin
			pa_q <= place_rdata;
		end
		if (state_q == S_CALC) begin
			pair_q <= pair;
		end
		if (state_q == S_SQ1) begin
			c0_q <= pair_q.plus0 ? ASCII_PLUS : ASCII_UC_A + {3'b000, sq_rdata};
		end
		if (state_q == S_SQ2) begin
			c1_q <= pair_q.pad1 ? ASCII_DASH :
				(pair_q.plus1 ? ASCII_PLUS : ASCII_UC_A + {3'b000, sq_rdata});
		end
		if (state_q == S_EM0 && out_free) begin
			rsp_q.out_char <= c0_q;
			rsp_q.last     <= 1'b0;
		end
		if (state_q == S_EM1 && out_free) begin
			rsp_q.out_char <= c1_q;
			rsp_q.last     <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PFC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FULL_COUNT)
	`PFC_ASSERT_NEXT(a_pair_second, rsp_valid && rsp_ready && !rsp.last, rsp_valid && rsp.last)
	`PFC_ASSERT_NOW(a_text_needs_key, state_q == S_RDA, full && held_valid_q)
	`PFC_ASSERT_NOW(a_walk_bound, state_q == S_WALK, walk_q <= LAST_LETTER)

endmodule

// ===== sv/pfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/pfc_pair_unit.sv =====
// Row/column arithmetic that turns two square places into two result cells.
// Depends on pfc_pkg.
module pfc_pair_unit import pfc_pkg::*; (
	input  cell_t     place_a,
	input  cell_t     place_b,
	input  logic      a_is_j,
	input  logic      b_is_j,
	input  logic      tail,
	output pfc_pair_t pair
);

	coord_t r0, c0, r1, c1;

	always_comb begin
		r0 = cell_row(place_a);
		c0 = cell_col(place_a);
		r1 = cell_row(place_b);
		c1 = cell_col(place_b);
		pair = '0;
		priority if (tail) begin
			pair.idx0  = make_cell(inc5(r0), inc5(c0));
			pair.plus0 = a_is_j;
			pair.pad1  = 1'b1;
		end else if (a_is_j && b_is_j) begin
			pair.plus0 = 1'b1;
			pair.plus1 = 1'b1;
		end else if (a_is_j) begin
			// J sits in the cell of I, so its column is c0.
			pair.plus0 = 1'b1;
			pair.idx1  = make_cell(r1, c0);
		end else if (b_is_j) begin
			pair.idx0  = make_cell(r0, c1);
			pair.plus1 = 1'b1;
		end else if (r0 != r1 && c0 != c1) begin
			pair.idx0 = make_cell(r0, c1);
			pair.idx1 = make_cell(r1, c0);
		end else if (r0 == r1 && c0 != c1) begin
			pair.idx0 = make_cell(r0, inc5(c0));
			pair.idx1 = make_cell(r1, inc5(c1));
		end else if (r0 != r1) begin
			pair.idx0 = make_cell(inc5(r0), c0);
			pair.idx1 = make_cell(inc5(r1), c1);
		end else begin
			pair.idx0 = make_cell(inc5(r0), inc5(c0));
			pair.idx1 = make_cell(inc5(r0), inc5(c0));
		end
	end

endmodule
